// ===== rtl/mandelbrot_escape_time_core_macros.svh =====
// Assertion macros for the escape-time core. Both expect clk and rst_n in scope.
`ifndef MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH

`ifndef SYNTH
`define MBET_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbet: same-cycle check failed");
`define MBET_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbet: next-cycle check failed");
`else
`define MBET_ASSERT_IMP(name, ante, cons)
`define MBET_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== rtl/mbet_pkg.sv =====
package mbet_pkg;

  localparam int FRAC_BITS = 28;
  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int Z_W       = 36;
  localparam int SUM_W     = 44;
  localparam int CNT_W     = 10;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [Z_W-1:0]    zval_t;

  typedef enum logic [2:0] {
    CFG_X_ORIGIN   = 3'd0,
    CFG_Y_ORIGIN   = 3'd1,
    CFG_X_STEP     = 3'd2,
    CFG_Y_STEP     = 3'd3,
    CFG_MAX_ITER   = 3'd4,
    CFG_ESC_RADIUS = 3'd5
  } cfg_reg_t;

  localparam logic [31:0] X_ORIGIN_RST = 32'hE000_0000;
  localparam logic [31:0] Y_ORIGIN_RST = 32'hE800_0000;
  localparam logic [30:0] X_STEP_RST   = 31'd447392;
  localparam logic [30:0] Y_STEP_RST   = 31'd805306;
  localparam logic [9:0]  MAX_ITER_RST = 10'd100;
  localparam logic [2:0]  RADIUS_RST   = 3'd2;

  localparam logic [9:0]  INT_FULL_CNT = 10'd100;
  localparam logic [20:0] INT_SCALE    = 21'd1336965;
  localparam int          INT_SHIFT    = 19;

  function automatic word_t sat32(input logic signed [SUM_W-1:0] v);
    word_t res;
    if (v[SUM_W-1:WORD_W-1] == '0 || v[SUM_W-1:WORD_W-1] == '1) begin
      res = v[WORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      res = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return res;
  endfunction

  // floor(n*255/100) by reciprocal, saturated above the full-scale count
  function automatic logic [7:0] intensity(input logic [CNT_W-1:0] n);
    logic [27:0] scaled;
    logic [7:0]  res;
    scaled = 28'(n[6:0]) * 28'(INT_SCALE);
    if (n > INT_FULL_CNT) begin
      res = 8'hFF;
    end else begin
      res = scaled[INT_SHIFT+7:INT_SHIFT];
    end
    return res;
  endfunction

endpackage

// ===== rtl/mbet_mul.sv =====
module mbet_mul (
  input  logic          clk,
  input  mbet_pkg::word_t a,
  input  mbet_pkg::word_t b,
  output mbet_pkg::prod_t prod
);
  import mbet_pkg::*;

  prod_t prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign prod = prod_r;

endmodule

// ===== rtl/mandelbrot_escape_time_core.sv =====
// Channel | Ports                                          | Direction | Handshake
// --------+------------------------------------------------+-----------+-------------------
// input   | in_column, in_row                              | in        | start & !busy
// result  | out_iterations_left, out_escaped, out_intensity| out       | out_valid strobe
// config  | cfg_index, cfg_data                            | in        | cfg_valid & cfg_ready
//
// An item passes the setup states S_CX, S_CY, S_CI, then iterates S_MRR, S_MII, S_MRI,
// S_UPD (out from S_MRR when it escapes on the component bound; none if max_iter is 0)
// and ends in S_RES. The single 32x32 multiplier is used three times per iteration.
// busy is high from just after acceptance through the cycle before the result strobe.
// Synchronous active-low reset sets state, out_valid and config registers to defaults.
// cfg_ready is low while busy; the result strobe lasts one cycle and is not held off.
`include "mandelbrot_escape_time_core_macros.svh"

module mandelbrot_escape_time_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [10:0] in_column,
  input  logic [9:0]  in_row,
  output logic        out_valid,
  output logic [9:0]  out_iterations_left,
  output logic        out_escaped,
  output logic [7:0]  out_intensity,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mbet_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CX   = 9'b000000010,
    S_CY   = 9'b000000100,
    S_CI   = 9'b000001000,
    S_MRR  = 9'b000010000,
    S_MII  = 9'b000100000,
    S_MRI  = 9'b001000000,
    S_UPD  = 9'b010000000,
    S_RES  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0]      x_origin_r, y_origin_r;
  logic [30:0]      x_step_r, y_step_r;
  logic [CNT_W-1:0] max_iter_r;
  logic [2:0]       radius_r;

  logic [10:0]      col_r, col_nxt;
  logic [9:0]       row_r, row_nxt;
  word_t            cr_r, cr_nxt, ci_r, ci_nxt;
  zval_t            zr_r, zr_nxt, zi_r, zi_nxt;
  prod_t            sqr_r, sqr_nxt, sqi_r, sqi_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             esc_r, esc_nxt;

  logic             out_valid_r;
  logic [CNT_W-1:0] out_iter_r;
  logic             out_esc_r;
  logic [7:0]       out_int_r;

  word_t            mul_a, mul_b;
  prod_t            prod;

  logic signed [SUM_W-1:0] sum_c;
  word_t                   c_sat;
  zval_t                   rfix;
  logic [PROD_W-1:0]       mag2, r2;
  prod_t                   nr_full, ni_full;
  logic                    esc_mag, esc_sq;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;

  mbet_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    cr_nxt    = cr_r;
    ci_nxt    = ci_r;
    zr_nxt    = zr_r;
    zi_nxt    = zi_r;
    sqr_nxt   = sqr_r;
    sqi_nxt   = sqi_r;
    cnt_nxt   = cnt_r;
    esc_nxt   = esc_r;
    mul_a     = '0;
    mul_b     = '0;

    if (state_r == S_CY) begin
      sum_c = SUM_W'($signed(x_origin_r)) + $signed({1'b0, prod[SUM_W-2:0]});
    end else begin
      sum_c = SUM_W'($signed(y_origin_r)) + $signed({1'b0, prod[SUM_W-2:0]});
    end
    c_sat = sat32(sum_c);

    rfix    = $signed(Z_W'(radius_r) << FRAC_BITS);
    esc_mag = (zr_r > rfix) || (zr_r < -rfix) || (zi_r > rfix) || (zi_r < -rfix);
    mag2    = sqr_r + sqi_r;
    r2      = (PROD_W'(radius_r) * PROD_W'(radius_r)) << (2 * FRAC_BITS);
    esc_sq  = mag2 > r2;
    nr_full = ((sqr_r - sqi_r) >>> FRAC_BITS) + PROD_W'(cr_r);
    ni_full = (prod >>> (FRAC_BITS - 1)) + PROD_W'(ci_r);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          col_nxt   = in_column;
          row_nxt   = in_row;
          state_nxt = S_CX;
        end
      end
      S_CX: begin
        mul_a     = {20'd0, 12'(col_r) + 12'd1};
        mul_b     = {1'b0, x_step_r};
        state_nxt = S_CY;
      end
      S_CY: begin
        mul_a     = {21'd0, 11'(row_r) + 11'd1};
        mul_b     = {1'b0, y_step_r};
        cr_nxt    = c_sat;
        state_nxt = S_CI;
      end
      S_CI: begin
        ci_nxt  = c_sat;
        zr_nxt  = Z_W'(cr_r);
        zi_nxt  = Z_W'(c_sat);
        cnt_nxt = max_iter_r;
        esc_nxt = 1'b0;
        if (max_iter_r == '0) begin
          state_nxt = S_RES;
        end else begin
          state_nxt = S_MRR;
        end
      end
      S_MRR: begin
        mul_a = zr_r[WORD_W-1:0];
        mul_b = zr_r[WORD_W-1:0];
        if (esc_mag) begin
          esc_nxt   = 1'b1;
          state_nxt = S_RES;
        end else begin
          state_nxt = S_MII;
        end
      end
      S_MII: begin
        mul_a     = zi_r[WORD_W-1:0];
        mul_b     = zi_r[WORD_W-1:0];
        sqr_nxt   = prod;
        state_nxt = S_MRI;
      end
      S_MRI: begin
        mul_a     = zr_r[WORD_W-1:0];
        mul_b     = zi_r[WORD_W-1:0];
        sqi_nxt   = prod;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (esc_sq) begin
          esc_nxt   = 1'b1;
          state_nxt = S_RES;
        end else if (cnt_r == CNT_W'(1)) begin
          cnt_nxt   = '0;
          state_nxt = S_RES;
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          zr_nxt    = nr_full[Z_W-1:0];
          zi_nxt    = ni_full[Z_W-1:0];
          state_nxt = S_MRR;
        end
      end
      S_RES: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      x_origin_r  <= X_ORIGIN_RST;
      y_origin_r  <= Y_ORIGIN_RST;
      x_step_r    <= X_STEP_RST;
      y_step_r    <= Y_STEP_RST;
      max_iter_r  <= MAX_ITER_RST;
      radius_r    <= RADIUS_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_RES);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_X_ORIGIN:   x_origin_r <= cfg_data;
          CFG_Y_ORIGIN:   y_origin_r <= cfg_data;
          CFG_X_STEP:     x_step_r   <= cfg_data[30:0];
          CFG_Y_STEP:     y_step_r   <= cfg_data[30:0];
          CFG_MAX_ITER:   max_iter_r <= cfg_data[CNT_W-1:0];
          CFG_ESC_RADIUS: radius_r   <= cfg_data[2:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
    row_r <= row_nxt;
    cr_r  <= cr_nxt;
    ci_r  <= ci_nxt;
    zr_r  <= zr_nxt;
    zi_r  <= zi_nxt;
    sqr_r <= sqr_nxt;
    sqi_r <= sqi_nxt;
    cnt_r <= cnt_nxt;
    esc_r <= esc_nxt;
    if (state_r == S_RES) begin
      out_iter_r <= cnt_r;
      out_esc_r  <= esc_r;
      out_int_r  <= intensity(cnt_r);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_iterations_left = out_iter_r;
  assign out_escaped         = out_esc_r;
  assign out_intensity       = out_int_r;

  `MBET_ASSERT_NXT(a_single_strobe, out_valid_r, !out_valid_r)
  `MBET_ASSERT_NXT(a_start_takes, start && !busy, busy && !out_valid_r)
  `MBET_ASSERT_IMP(a_budget_spent, out_valid_r && !out_esc_r, out_iter_r == '0)
  `MBET_ASSERT_IMP(a_escape_count, out_valid_r && out_esc_r, out_iter_r != '0)

endmodule
